// File: hw/rtl/tlsi_pkg.sv
// Shared constants and types for the three-list sorted intersection block.
`timescale 1ns / 1ps
`default_nettype none
package tlsi_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WIDTH_DEFAULT = 32;
    localparam int MAX_RESULTS   = 64;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

    // request codes
    localparam logic [1:0] REQ_APPEND_A = 2'd0;
    localparam logic [1:0] REQ_APPEND_B = 2'd1;
    localparam logic [1:0] REQ_APPEND_C = 2'd2;
    localparam logic [1:0] REQ_RUN      = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;    // append i_value to the list picked by req_type
        logic step;    // act on the current heads: emit or advance
        logic finish;  // post the final item and clear the lists
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_done;    // a list is exhausted or the result cap is hit
        logic match;        // all three heads are equal
        logic have_pending; // a found value waits for its last mark
        logic can_push;     // output register can take an item this cycle
    } t_status;

endpackage
`default_nettype wire

// File: hw/rtl/tlsi_ctrl.sv
// Sequencer for loads and the intersection walk.
`timescale 1ns / 1ps
`default_nettype none
module tlsi_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [1:0]      i_req_type,
    input  wire tlsi_pkg::t_status i_status,
    output logic                 o_in_ready,
    output tlsi_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CMP,
        S_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == tlsi_pkg::REQ_RUN) begin
                        n_state = S_FETCH;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_status.walk_done) begin
                    n_state = S_FINAL;
                end else if (i_status.match && i_status.have_pending &&
                             !i_status.can_push) begin
                    n_state = S_CMP;    // hold until the older item drains
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_FETCH;
                end
            end
            S_FINAL: begin
                if (i_status.can_push) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tlsi_datapath.sv
// List stores, walk pointers, pending result and output register.
`timescale 1ns / 1ps
`default_nettype none
module tlsi_datapath #(
    parameter int DEPTH = tlsi_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = tlsi_pkg::WIDTH_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tlsi_pkg::t_cmd     i_cmd,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_out_ready,
    output tlsi_pkg::t_status       o_status,
    output logic                    o_out_valid,
    output logic signed [31:0]      o_common_value,
    output logic                    o_found,
    output logic                    o_last,
    output logic                    o_overflowed
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RES_W  = tlsi_pkg::RES_CNT_W;

    logic signed [WIDTH-1:0] r_mem_a [DEPTH];
    logic signed [WIDTH-1:0] r_mem_b [DEPTH];
    logic signed [WIDTH-1:0] r_mem_c [DEPTH];
    logic signed [WIDTH-1:0] r_head_a, r_head_b, r_head_c;

    logic [CNT_W-1:0] r_cnt_a, r_cnt_b, r_cnt_c;
    logic [CNT_W-1:0] r_ptr_a, r_ptr_b, r_ptr_c;
    logic [RES_W-1:0] r_nres;
    logic             r_ovf;

    logic signed [WIDTH-1:0] r_pend;
    logic                    r_have_pend;

    logic signed [WIDTH-1:0] value_w;
    logic                    push_step;
    logic                    full_a, full_b, full_c;

    assign value_w = WIDTH'(i_value);
    assign full_a  = (r_cnt_a >= CNT_W'(DEPTH));
    assign full_b  = (r_cnt_b >= CNT_W'(DEPTH));
    assign full_c  = (r_cnt_c >= CNT_W'(DEPTH));

    // stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_req_type == tlsi_pkg::REQ_APPEND_A && !full_a) begin
            r_mem_a[r_cnt_a[ADDR_W-1:0]] <= value_w;
        end
        if (i_cmd.load && i_req_type == tlsi_pkg::REQ_APPEND_B && !full_b) begin
            r_mem_b[r_cnt_b[ADDR_W-1:0]] <= value_w;
        end
        if (i_cmd.load && i_req_type == tlsi_pkg::REQ_APPEND_C && !full_c) begin
            r_mem_c[r_cnt_c[ADDR_W-1:0]] <= value_w;
        end
        r_head_a <= r_mem_a[r_ptr_a[ADDR_W-1:0]];
        r_head_b <= r_mem_b[r_ptr_b[ADDR_W-1:0]];
        r_head_c <= r_mem_c[r_ptr_c[ADDR_W-1:0]];
    end

    assign o_status.walk_done = (r_ptr_a >= r_cnt_a) || (r_ptr_b >= r_cnt_b) ||
                                (r_ptr_c >= r_cnt_c) ||
                                (r_nres >= RES_W'(tlsi_pkg::MAX_RESULTS));
    assign o_status.match        = (r_head_a == r_head_b) && (r_head_b == r_head_c);
    assign o_status.have_pending = r_have_pend;
    assign o_status.can_push     = !o_out_valid || i_out_ready;

    assign push_step = i_cmd.step && o_status.match && r_have_pend;

    // counts, pointers, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_cnt_c     <= '0;
            r_ptr_a     <= '0;
            r_ptr_b     <= '0;
            r_ptr_c     <= '0;
            r_nres      <= '0;
            r_ovf       <= 1'b0;
            r_have_pend <= 1'b0;
        end else if (i_cmd.finish) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_cnt_c     <= '0;
            r_ptr_a     <= '0;
            r_ptr_b     <= '0;
            r_ptr_c     <= '0;
            r_nres      <= '0;
            r_ovf       <= 1'b0;
            r_have_pend <= 1'b0;
        end else if (i_cmd.load) begin
            case (i_req_type)
                tlsi_pkg::REQ_APPEND_A: begin
                    if (full_a) r_ovf <= 1'b1;
                    else r_cnt_a <= r_cnt_a + CNT_W'(1);
                end
                tlsi_pkg::REQ_APPEND_B: begin
                    if (full_b) r_ovf <= 1'b1;
                    else r_cnt_b <= r_cnt_b + CNT_W'(1);
                end
                tlsi_pkg::REQ_APPEND_C: begin
                    if (full_c) r_ovf <= 1'b1;
                    else r_cnt_c <= r_cnt_c + CNT_W'(1);
                end
                default: begin
                end
            endcase
        end else if (i_cmd.step) begin
            if (o_status.match) begin
                r_ptr_a     <= r_ptr_a + CNT_W'(1);
                r_ptr_b     <= r_ptr_b + CNT_W'(1);
                r_ptr_c     <= r_ptr_c + CNT_W'(1);
                r_nres      <= r_nres + RES_W'(1);
                r_have_pend <= 1'b1;
            end else if (r_head_a <= r_head_b && r_head_a <= r_head_c) begin
                r_ptr_a <= r_ptr_a + CNT_W'(1);
            end else if (r_head_b <= r_head_c) begin
                r_ptr_b <= r_ptr_b + CNT_W'(1);
            end else begin
                r_ptr_c <= r_ptr_c + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && o_status.match) begin
            r_pend <= r_head_a;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (push_step || i_cmd.finish) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_step) begin
            o_common_value <= 32'(r_pend);
            o_found        <= 1'b1;
            o_last         <= 1'b0;
            o_overflowed   <= r_ovf;
        end else if (i_cmd.finish) begin
            o_common_value <= r_have_pend ? 32'(r_pend) : 32'sd0;
            o_found        <= r_have_pend;
            o_last         <= 1'b1;
            o_overflowed   <= r_ovf;
        end
    end

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr_a <= r_cnt_a) && (r_ptr_b <= r_cnt_b) && (r_ptr_c <= r_cnt_c))
        else $error("walk pointer past list end");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(DEPTH)) && (r_cnt_b <= CNT_W'(DEPTH)) &&
        (r_cnt_c <= CNT_W'(DEPTH)))
        else $error("list count above capacity");

    a_res_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= RES_W'(tlsi_pkg::MAX_RESULTS))
        else $error("result count above cap");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_common_value) && $stable(o_last)))
        else $error("waiting output item overwritten");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> o_last)
        else $error("empty answer without last mark");

endmodule
`default_nettype wire

// File: hw/rtl/three_list_sorted_intersection.sv
// Top level of the three-list sorted intersection block.
`timescale 1ns / 1ps
`default_nettype none
// Three lists of signed WIDTH-bit elements, each up to DEPTH long, are filled
// by append items (req_type A, B or C); a full list drops the append and sets
// the overflow mark. A run item walks the lists with one pointer each,
// advancing the smallest head, and emits each value present in all three,
// ascending, with the final item marked last; with no common value a single
// item with found clear is given. At most 64 items come from one run. Each
// run empties the lists and clears the overflow mark after reporting it.
// Sequence: an append leaves the block idle and ready for the next item. A
// run takes each pointer step through a fetch state for the registered store
// read and then a compare state, with at most count_a + count_b + count_c
// steps; the compare state and the final item also wait while the output
// side stalls. No new item is taken during a run.
// The output register holds one finished item and the next found value waits
// in a pending register until it is known whether it is the last.
module three_list_sorted_intersection #(
    parameter int DEPTH = tlsi_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = tlsi_pkg::WIDTH_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input item channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_value,
    // result item channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_common_value,
    output logic                    o_found,
    output logic                    o_last,
    output logic                    o_overflowed
);

    tlsi_pkg::t_cmd    cmd;
    tlsi_pkg::t_status status;

    // sequencer: idle/append, fetch heads, compare, final item
    tlsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // stores, pointers and the output register
    tlsi_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .i_out_ready    (i_out_ready),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_common_value (o_common_value),
        .o_found        (o_found),
        .o_last         (o_last),
        .o_overflowed   (o_overflowed)
    );

endmodule
`default_nettype wire
